>>> src/http_request_frame_detector_assert.svh
// assertion macros for the http request frame detector
// expects a clock named clk and an active-low reset named rst_n in the including module
`ifndef HTTP_REQUEST_FRAME_DETECTOR_ASSERT_SVH
`define HTTP_REQUEST_FRAME_DETECTOR_ASSERT_SVH

// check a property on every rising edge outside reset
`define HRFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check an implication that holds in the same cycle
`define HRFD_ASSERT_IMPL(label, cond, prop, msg) \
    `HRFD_ASSERT(label, (cond) |-> (prop), msg)

`endif

>>> src/hrfd_pkg.sv
// types, codes and match tables for the http request frame detector
// no dependencies
package hrfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MAXLEN_W    = 20;
    localparam int unsigned VALUE_W     = 21;
    localparam int unsigned PKTLEN_W    = 22;
    localparam int unsigned OUTCOME_W   = 3;
    localparam int unsigned HDR_POS_W   = 4;
    localparam int unsigned MPOS_W      = 3;
    localparam logic [VALUE_W-1:0]  VALUE_CAP     = 21'h100000;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET  = 20'h10000;
    localparam logic [HDR_POS_W-1:0] HDR_LAST     = 4'd15;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_SCAN   = 3'd1,
        PH_SEP1   = 3'd2,
        PH_SEPS   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_REST   = 3'd5,
        PH_BODY   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        MK_NONE    = 2'd0,
        MK_GET     = 2'd1,
        MK_POST    = 2'd2,
        MK_UNKNOWN = 2'd3
    } method_t;

    typedef enum logic [2:0] {
        OC_BUSY       = 3'd0,
        OC_GET_DONE   = 3'd1,
        OC_POST_DONE  = 3'd2,
        OC_BAD_METHOD = 3'd3,
        OC_NO_LENGTH  = 3'd4,
        OC_TOO_LONG   = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        CR_NONE  = 2'd0,
        CR_CR    = 2'd1,
        CR_CRLF  = 2'd2,
        CR_CRLFC = 2'd3
    } crlf_t;

    localparam logic [1:0] REG_MAX_BODY = 2'd0;

    // fold ascii upper case to lower case
    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // "\r\ncontent-length" in lower case
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [HDR_POS_W-1:0] p);
        logic [BYTE_W-1:0] r;
        case (p)
            4'd0:    r = 8'h0d;
            4'd1:    r = 8'h0a;
            4'd2:    r = "c";
            4'd3:    r = "o";
            4'd4:    r = "n";
            4'd5:    r = "t";
            4'd6:    r = "e";
            4'd7:    r = "n";
            4'd8:    r = "t";
            4'd9:    r = "-";
            4'd10:   r = "l";
            4'd11:   r = "e";
            4'd12:   r = "n";
            4'd13:   r = "g";
            4'd14:   r = "t";
            default: r = "h";
        endcase
        return r;
    endfunction

    // later letters of "GET"; position zero is decided separately
    function automatic logic get_match(input logic [MPOS_W-1:0] p, input logic [BYTE_W-1:0] c);
        logic r;
        case (p)
            3'd1:    r = (c == "E");
            3'd2:    r = (c == "T");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // later letters of "POST"
    function automatic logic post_match(input logic [MPOS_W-1:0] p, input logic [BYTE_W-1:0] c);
        logic r;
        case (p)
            3'd1:    r = (c == "O");
            3'd2:    r = (c == "S");
            3'd3:    r = (c == "T");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> src/http_request_frame_detector.sv
// http request frame detector, top level
// depends on hrfd_pkg and http_request_frame_detector_assert.svh
// Takes one request-stream byte per transfer and returns one result transfer per byte, in
// order. An input register holds the byte, combinational match and count logic updates
// the request state and fills the output register, so a new byte is taken every cycle
// while the output side keeps up. A GET request ends at its first blank line; a POST
// request ends content-length body bytes after it, the length taken from the first
// case-insensitive content-length header. Unknown methods, a POST without a usable length,
// and lengths above max_body_length end at the blank line with an error outcome. m_tlast
// marks the byte that ends a request; the total byte count is then in the packet_length
// field (zero otherwise) and the detector starts a new request with the next byte. The
// byte count saturates at 2^LENGTH_BITS - 1.
`include "http_request_frame_detector_assert.svh"

module http_request_frame_detector #(
    parameter int unsigned LENGTH_BITS = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [2:0] outcome, [24:3] packet_length, [31:25] zero
    output logic        m_tlast,    // frame_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CNT_W = LENGTH_BITS;
    localparam int unsigned PRODUCT_W = hrfd_pkg::VALUE_W + 4;

    // ---------------- configuration register ----------------
    logic [hrfd_pkg::MAXLEN_W-1:0] max_body_reg;
    logic                          cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == hrfd_pkg::REG_MAX_BODY[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg <= hrfd_pkg::MAXLEN_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            max_body_reg <= pwdata[hrfd_pkg::MAXLEN_W-1:0];
        end
    end

    assign prdata = cfg_hit ? {12'd0, max_body_reg} : 32'd0;

    // ---------------- input register and flow control ----------------
    logic                        in_valid_reg;
    logic [hrfd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    logic                        out_free;
    logic                        advance;

    // the output register frees up when it is empty or its transfer completes
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // ---------------- request state ----------------
    hrfd_pkg::phase_t              phase_reg, phase_next;
    hrfd_pkg::method_t             kind_reg, kind_next;
    logic [hrfd_pkg::MPOS_W-1:0]   mpos_reg, mpos_next;
    hrfd_pkg::crlf_t               crlf_reg, crlf_next;
    logic [hrfd_pkg::HDR_POS_W-1:0] hpos_reg, hpos_next;
    logic                          seen_reg, seen_next;
    logic [hrfd_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [hrfd_pkg::VALUE_W-1:0]  remain_reg, remain_next;

    // per-byte intermediate values, before the end-of-request decision
    logic [hrfd_pkg::BYTE_W-1:0]   c;
    logic                          is_digit;
    logic [3:0]                    digit;
    logic [PRODUCT_W-1:0]          product;
    hrfd_pkg::crlf_t               crlf_upd;
    logic                          blank;
    hrfd_pkg::phase_t              phase_upd;
    hrfd_pkg::method_t             kind_upd;
    logic [hrfd_pkg::MPOS_W-1:0]   mpos_upd;
    logic [hrfd_pkg::HDR_POS_W-1:0] hpos_upd;
    logic                          seen_upd;
    logic [hrfd_pkg::VALUE_W-1:0]  value_upd;
    logic [hrfd_pkg::VALUE_W-1:0]  remain_dec;
    logic [CNT_W-1:0]              count_inc;
    hrfd_pkg::outcome_t            code;
    logic                          enter_body;

    assign c        = in_byte_reg;
    assign is_digit = (c >= hrfd_pkg::CH_ZERO) && (c <= hrfd_pkg::CH_NINE);
    assign digit    = 4'(c - hrfd_pkg::CH_ZERO);
    // value * 10 + digit as two shifts and an add
    assign product  = (PRODUCT_W'(value_reg) << 3) + (PRODUCT_W'(value_reg) << 1)
                    + PRODUCT_W'(digit);

    assign count_inc  = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    // blank line search, runs on every byte outside the body
    always_comb
    begin
        crlf_upd = crlf_reg;
        blank    = 1'b0;
        if (c == hrfd_pkg::CH_CR)
        begin
            crlf_upd = (crlf_reg == hrfd_pkg::CR_CRLF) ? hrfd_pkg::CR_CRLFC : hrfd_pkg::CR_CR;
        end
        else if (c == hrfd_pkg::CH_LF && crlf_reg == hrfd_pkg::CR_CR)
        begin
            crlf_upd = hrfd_pkg::CR_CRLF;
        end
        else if (c == hrfd_pkg::CH_LF && crlf_reg == hrfd_pkg::CR_CRLFC)
        begin
            blank = 1'b1;
        end
        else
        begin
            crlf_upd = hrfd_pkg::CR_NONE;
        end
    end

    // method, header and length matching within the current phase
    always_comb
    begin
        phase_upd = phase_reg;
        kind_upd  = kind_reg;
        mpos_upd  = mpos_reg;
        hpos_upd  = hpos_reg;
        seen_upd  = seen_reg;
        value_upd = value_reg;
        unique case (phase_reg) inside
            hrfd_pkg::PH_METHOD:
            begin
                if (mpos_reg == '0)
                begin
                    kind_upd = (c == "G") ? hrfd_pkg::MK_GET :
                               (c == "P") ? hrfd_pkg::MK_POST : hrfd_pkg::MK_UNKNOWN;
                end
                else if (kind_reg == hrfd_pkg::MK_GET)
                begin
                    if (!hrfd_pkg::get_match(mpos_reg, c))
                    begin
                        kind_upd = hrfd_pkg::MK_UNKNOWN;
                    end
                end
                else if (kind_reg == hrfd_pkg::MK_POST)
                begin
                    if (!hrfd_pkg::post_match(mpos_reg, c))
                    begin
                        kind_upd = hrfd_pkg::MK_UNKNOWN;
                    end
                end
                else
                begin
                    kind_upd = hrfd_pkg::MK_UNKNOWN;
                end
                mpos_upd = mpos_reg + 1'b1;
                if (kind_upd == hrfd_pkg::MK_UNKNOWN
                    || (kind_upd == hrfd_pkg::MK_GET && mpos_upd == 3'd3)
                    || (kind_upd == hrfd_pkg::MK_POST && mpos_upd == 3'd4))
                begin
                    phase_upd = hrfd_pkg::PH_SCAN;
                end
            end
            hrfd_pkg::PH_SCAN:
            begin
                // header search only matters for POST
                if (kind_reg == hrfd_pkg::MK_POST)
                begin
                    if (hrfd_pkg::to_lower(c) == hrfd_pkg::hdr_char(hpos_reg))
                    begin
                        if (hpos_reg == hrfd_pkg::HDR_LAST)
                        begin
                            hpos_upd  = '0;
                            phase_upd = hrfd_pkg::PH_SEP1;
                        end
                        else
                        begin
                            hpos_upd = hpos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        hpos_upd = (c == hrfd_pkg::CH_CR) ? 4'd1 : 4'd0;
                    end
                end
            end
            hrfd_pkg::PH_SEP1, hrfd_pkg::PH_SEPS:
            begin
                if (c == hrfd_pkg::CH_COLON || c == hrfd_pkg::CH_SPACE)
                begin
                    phase_upd = hrfd_pkg::PH_SEPS;
                end
                else if (phase_reg == hrfd_pkg::PH_SEPS && is_digit)
                begin
                    seen_upd  = 1'b1;
                    value_upd = hrfd_pkg::VALUE_W'(digit);
                    phase_upd = hrfd_pkg::PH_DIGITS;
                end
                else
                begin
                    phase_upd = hrfd_pkg::PH_REST;
                end
            end
            hrfd_pkg::PH_DIGITS:
            begin
                if (is_digit)
                begin
                    // saturate just above the 20-bit register range
                    value_upd = (product > PRODUCT_W'(hrfd_pkg::VALUE_CAP)) ?
                                hrfd_pkg::VALUE_CAP : product[hrfd_pkg::VALUE_W-1:0];
                end
                else
                begin
                    phase_upd = hrfd_pkg::PH_REST;
                end
            end
            default:
            begin
                // rest of headers and body: nothing to match; body bytes ignore these updates
            end
        endcase
    end

    // outcome of this byte
    always_comb
    begin
        code       = hrfd_pkg::OC_BUSY;
        enter_body = 1'b0;
        if (phase_reg == hrfd_pkg::PH_BODY)
        begin
            if (remain_dec == '0)
            begin
                code = hrfd_pkg::OC_POST_DONE;
            end
        end
        else if (blank)
        begin
            if (kind_upd == hrfd_pkg::MK_GET)
            begin
                code = hrfd_pkg::OC_GET_DONE;
            end
            else if (kind_upd != hrfd_pkg::MK_POST)
            begin
                code = hrfd_pkg::OC_BAD_METHOD;
            end
            else if (!seen_upd)
            begin
                code = hrfd_pkg::OC_NO_LENGTH;
            end
            else if (value_upd > {1'b0, max_body_reg})
            begin
                code = hrfd_pkg::OC_TOO_LONG;
            end
            else if (value_upd == '0)
            begin
                code = hrfd_pkg::OC_POST_DONE;
            end
            else
            begin
                enter_body = 1'b1;
            end
        end
    end

    // next state: restart after an outcome, hold the header state in the body, else take the updates
    always_comb
    begin
        phase_next  = phase_upd;
        kind_next   = kind_upd;
        mpos_next   = mpos_upd;
        crlf_next   = crlf_upd;
        hpos_next   = hpos_upd;
        seen_next   = seen_upd;
        value_next  = value_upd;
        count_next  = count_inc;
        remain_next = remain_reg;
        if (phase_reg == hrfd_pkg::PH_BODY)
        begin
            phase_next  = phase_reg;
            kind_next   = kind_reg;
            mpos_next   = mpos_reg;
            crlf_next   = crlf_reg;
            hpos_next   = hpos_reg;
            seen_next   = seen_reg;
            value_next  = value_reg;
            remain_next = remain_dec;
        end
        else if (enter_body)
        begin
            phase_next  = hrfd_pkg::PH_BODY;
            remain_next = value_upd;
            crlf_next   = hrfd_pkg::CR_NONE;
        end
        if (code != hrfd_pkg::OC_BUSY)
        begin
            phase_next  = hrfd_pkg::PH_METHOD;
            kind_next   = hrfd_pkg::MK_NONE;
            mpos_next   = '0;
            crlf_next   = hrfd_pkg::CR_NONE;
            hpos_next   = '0;
            seen_next   = 1'b0;
            value_next  = '0;
            count_next  = '0;
            remain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrfd_pkg::PH_METHOD;
            kind_reg   <= hrfd_pkg::MK_NONE;
            mpos_reg   <= '0;
            crlf_reg   <= hrfd_pkg::CR_NONE;
            hpos_reg   <= '0;
            seen_reg   <= 1'b0;
            value_reg  <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            mpos_reg   <= mpos_next;
            crlf_reg   <= crlf_next;
            hpos_reg   <= hpos_next;
            seen_reg   <= seen_next;
            value_reg  <= value_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    // ---------------- output register ----------------
    logic [CNT_W+hrfd_pkg::PKTLEN_W-1:0] count_wide;
    logic [hrfd_pkg::PKTLEN_W-1:0]       pkt_len;
    logic                                out_last_reg;
    hrfd_pkg::outcome_t                  out_code_reg;
    logic [hrfd_pkg::PKTLEN_W-1:0]       out_len_reg;

    // count including this byte, cut or padded to the field width
    assign count_wide = {{hrfd_pkg::PKTLEN_W{1'b0}}, count_inc};
    assign pkt_len    = count_wide[hrfd_pkg::PKTLEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= (code != hrfd_pkg::OC_BUSY);
            out_code_reg <= code;
            out_len_reg  <= (code != hrfd_pkg::OC_BUSY) ? pkt_len : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_len_reg, out_code_reg};

    // ---------------- assertions ----------------
    `HRFD_ASSERT_IMPL(a_last_has_outcome, m_tvalid && m_tlast, m_tdata[2:0] != 3'd0,
        "frame end without an outcome")
    `HRFD_ASSERT_IMPL(a_busy_is_zero, m_tvalid && !m_tlast, m_tdata == 32'd0,
        "in-progress result carries nonzero fields")
    `HRFD_ASSERT_IMPL(a_body_is_post, phase_reg == hrfd_pkg::PH_BODY,
        kind_reg == hrfd_pkg::MK_POST && seen_reg && remain_reg != '0,
        "body phase without a pending POST length")
    `HRFD_ASSERT_IMPL(a_hdr_only_post, hpos_reg != '0,
        kind_reg == hrfd_pkg::MK_POST && phase_reg == hrfd_pkg::PH_SCAN,
        "header match progress outside POST header scan")

endmodule

>>> bench/http_request_frame_detector_test.sv
// self-checking bench for http_request_frame_detector: byte stream in, one status transfer out
// per byte, checked against an in-bench request framing tracker
// depends on hrfd_pkg and the detector rtl
module http_request_frame_detector_test;
    import hrfd_pkg::*;

    // byte count saturates at the packet_length width
    localparam int unsigned LEN_LIMIT   = (1 << PKTLEN_W) - 1;
    localparam int unsigned SEGMENTS    = 8;
    localparam int unsigned SEG_BYTES   = 220;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned RUN_LIMIT   = 1000000;
    localparam int unsigned PRINT_CAP   = 40;
    // a total of zero in the directed list means the tracker supplies the expectation
    localparam int unsigned PREDICTED   = 0;
    localparam logic [2:0]  LIMIT_ADDR  = 3'(4 * REG_MAX_BODY);

    // match words, first character in the top byte
    localparam logic [23:0]  GET_WORD  = "GET";
    localparam logic [31:0]  POST_WORD = "POST";
    localparam logic [127:0] HDR_WORD  = {CH_CR, CH_LF, "content-length"};

    typedef struct packed {
        logic                done;
        outcome_t            code;
        logic [PKTLEN_W-1:0] total;
    } frame_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [2:0] outcome, [24:3] packet_length
    logic        m_tlast;           // frame_done
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // request tracker state, mirrors the detector between transfers
    logic [MAXLEN_W-1:0] body_limit;
    phase_t              req_phase;
    method_t             req_method;
    logic [2:0]          method_pos;
    crlf_t               line_end;
    logic [3:0]          hdr_pos;
    logic                len_found;
    int unsigned         content_len;
    int unsigned         byte_count;
    int unsigned         body_left;

    frame_status_t status_q[$];     // expected status per accepted byte, oldest first
    logic [7:0]    req_q[$];        // bytes of the request being built

    // directed list, one row per request
    string         case_text[$];
    outcome_t      case_code[$];
    int unsigned   case_total[$];

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned outcome_hits [0:7];

    always #1 clk = ~clk;

    http_request_frame_detector uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // request framing tracker
    // ------------------------------------------------------------------

    function automatic void clear_request();
        req_phase   = PH_METHOD;
        req_method  = MK_NONE;
        method_pos  = '0;
        line_end    = CR_NONE;
        hdr_pos     = '0;
        len_found   = 1'b0;
        content_len = 0;
        byte_count  = 0;
        body_left   = 0;
    endfunction

    // advance the tracker by one byte and return the status the detector owes for it
    function automatic frame_status_t frame_step(input logic [7:0] c);
        frame_status_t r;
        outcome_t      code;
        logic          blank;
        logic          digit;
        logic [7:0]    folded;
        int unsigned   acc;
        code   = OC_BUSY;
        blank  = 1'b0;
        digit  = (c >= CH_ZERO && c <= CH_NINE);
        folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (byte_count < LEN_LIMIT)
            byte_count++;
        if (req_phase == PH_BODY)
        begin
            // body bytes are opaque, only counted down
            if (body_left > 0)
                body_left--;
            if (body_left == 0)
                code = OC_POST_DONE;
        end
        else
        begin
            // blank line search runs on every header byte
            if (c == CH_CR)
                line_end = (line_end == CR_CRLF) ? CR_CRLFC : CR_CR;
            else if (c == CH_LF && line_end == CR_CR)
                line_end = CR_CRLF;
            else if (c == CH_LF && line_end == CR_CRLFC)
                blank = 1'b1;
            else
                line_end = CR_NONE;

            case (req_phase)
                PH_METHOD:
                begin
                    if (method_pos == 0)
                        req_method = (c == "G") ? MK_GET : (c == "P") ? MK_POST : MK_UNKNOWN;
                    else if (req_method == MK_GET)
                    begin
                        if (method_pos > 2)
                            req_method = MK_UNKNOWN;
                        else if (c != GET_WORD[8 * (2 - method_pos) +: 8])
                            req_method = MK_UNKNOWN;
                    end
                    else if (req_method == MK_POST)
                    begin
                        if (method_pos > 3)
                            req_method = MK_UNKNOWN;
                        else if (c != POST_WORD[8 * (3 - method_pos) +: 8])
                            req_method = MK_UNKNOWN;
                    end
                    else
                        req_method = MK_UNKNOWN;
                    method_pos = method_pos + 3'd1;
                    if (req_method == MK_UNKNOWN ||
                        (req_method == MK_GET && method_pos == 3) ||
                        (req_method == MK_POST && method_pos == 4))
                        req_phase = PH_SCAN;
                end
                PH_SCAN:
                begin
                    // only a post looks for the length header
                    if (req_method == MK_POST)
                    begin
                        if (folded == HDR_WORD[8 * (15 - hdr_pos) +: 8])
                        begin
                            if (hdr_pos == 15)
                            begin
                                hdr_pos   = '0;
                                req_phase = PH_SEP1;
                            end
                            else
                                hdr_pos = hdr_pos + 4'd1;
                        end
                        else
                            hdr_pos = (c == CH_CR) ? 4'd1 : 4'd0;
                    end
                end
                PH_SEP1, PH_SEPS:
                begin
                    if (c == CH_COLON || c == CH_SPACE)
                        req_phase = PH_SEPS;
                    else if (req_phase == PH_SEPS && digit)
                    begin
                        len_found   = 1'b1;
                        content_len = c - CH_ZERO;
                        req_phase   = PH_DIGITS;
                    end
                    else
                        req_phase = PH_REST;
                end
                PH_DIGITS:
                begin
                    if (digit)
                    begin
                        acc = content_len * 10 + (c - CH_ZERO);
                        content_len = (acc > VALUE_CAP) ? VALUE_CAP : acc;
                    end
                    else
                        req_phase = PH_REST;
                end
                default:
                    ;
            endcase

            if (blank)
            begin
                if (req_method == MK_GET)
                    code = OC_GET_DONE;
                else if (req_method != MK_POST)
                    code = OC_BAD_METHOD;
                else if (!len_found)
                    code = OC_NO_LENGTH;
                else if (content_len > body_limit)
                    code = OC_TOO_LONG;
                else if (content_len == 0)
                    code = OC_POST_DONE;
                else
                begin
                    body_left = content_len;
                    req_phase = PH_BODY;
                    line_end  = CR_NONE;
                end
            end
        end

        r.done  = (code != OC_BUSY);
        r.code  = code;
        r.total = r.done ? byte_count[PKTLEN_W-1:0] : '0;
        if (r.done)
            clear_request();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s after %0d results: got %0d, expected %0d",
                     $time, what, results_seen, got, want);
        mismatches++;
    endtask

    // sampled mid-cycle so the values are the ones the next rising edge takes
    always @(negedge clk)
    begin
        frame_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
                report_mismatch("result transfer with nothing pending", m_tdata, 0);
            else
            begin
                want = status_q.pop_front();
                if (m_tlast !== want.done)
                    report_mismatch("frame_done", m_tlast, want.done);
                if (m_tdata[OUTCOME_W-1:0] !== want.code)
                    report_mismatch("outcome", m_tdata[OUTCOME_W-1:0], want.code);
                if (m_tdata[OUTCOME_W +: PKTLEN_W] !== want.total)
                    report_mismatch("packet_length", m_tdata[OUTCOME_W +: PKTLEN_W],
                                    want.total);
                if (want.done)
                    outcome_hits[want.code]++;
            end
            results_seen++;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one byte transfer; a pinned status replaces the tracker's expectation
    task automatic send_byte(input logic [7:0] b, input logic pin,
                             input frame_status_t pinned);
        logic          taken;
        frame_status_t want;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            if (taken)
            begin
                want = frame_step(b);
                status_q.push_back(pin ? pinned : want);
                bytes_sent++;
            end
            @(posedge clk);
        end
    endtask

    task automatic send_request();
        while (req_q.size() != 0)
            send_byte(req_q.pop_front(), 1'b0, '0);
    endtask

    // stop sending until every status has come back, then let the pipe drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        logic done_flag;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        done_flag = 1'b0;
        while (!done_flag)
        begin
            @(negedge clk);
            done_flag = pready;
            rdata = prdata;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_body_limit(input logic [MAXLEN_W-1:0] value);
        logic [31:0] rd;
        apb_cycle(1'b0, '0, rd);
        if (rd[MAXLEN_W-1:0] !== value)
            report_mismatch("max_body_length readback", rd[MAXLEN_W-1:0], value);
    endtask

    task automatic set_body_limit(input logic [MAXLEN_W-1:0] value);
        logic [31:0] rd;
        apb_cycle(1'b1, {{(32 - MAXLEN_W){1'b0}}, value}, rd);
        body_limit = value;
        check_body_limit(value);
    endtask

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_q.push_back(s[i]);
    endfunction

    function automatic void put_eol();
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
    endfunction

    // printable filler, never a line end
    function automatic void put_filler(input int unsigned lo, input int unsigned hi);
        int unsigned n;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++)
            req_q.push_back(8'($urandom_range(8'h7e, 8'h20)));
    endfunction

    function automatic void put_header_lines(input int unsigned most);
        int unsigned n;
        n = $urandom_range(most);
        for (int i = 0; i < n; i++)
        begin
            put_filler(1, 12);
            put_eol();
        end
    endfunction

    // content-length in random letter case
    function automatic void put_length_name();
        string name;
        int unsigned n;
        name = "content-length";
        for (int i = 0; i < name.len(); i++)
        begin
            if (name[i] >= "a" && name[i] <= "z" && $urandom_range(1))
                req_q.push_back(name[i] - 8'd32);
            else
                req_q.push_back(name[i]);
        end
    endfunction

    function automatic void put_separators();
        int unsigned n;
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
            req_q.push_back($urandom_range(1) ? CH_COLON : CH_SPACE);
    endfunction

    function automatic void make_request();
        int unsigned pick;
        int unsigned val;
        int unsigned hi;
        logic        oversize;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            put_text("GET");
            put_filler(0, 12);
            put_eol();
            put_header_lines(3);
            put_eol();
        end
        else if (pick < 62)
        begin
            // well-formed post with a length, mostly within the current limit and sometimes above it
            oversize = ($urandom_range(99) < 18);
            if (oversize)
                val = $urandom_range(3) == 0 ? $urandom : body_limit + 1 + $urandom_range(1000);
            else
            begin
                hi  = ($urandom_range(19) == 0) ? 300 : 24;
                hi  = (body_limit < hi) ? body_limit : hi;
                val = $urandom_range(hi);
            end
            put_text("POST");
            put_filler(0, 12);
            put_eol();
            put_header_lines(2);
            put_length_name();
            put_separators();
            if ($urandom_range(4) == 0)
                put_text("00");
            put_text($sformatf("%0d", val));
            put_eol();
            put_header_lines(2);
            put_eol();
            if (!oversize)
                for (int i = 0; i < val; i++)
                    req_q.push_back(8'($urandom_range(255)));
        end
        else if (pick < 74)
        begin
            // post whose length is absent or unusable
            put_text("POST");
            put_filler(0, 8);
            put_eol();
            put_header_lines(2);
            case ($urandom_range(3))
                0: ;
                1:
                begin
                    put_length_name();
                    put_eol();
                end
                2:
                begin
                    put_length_name();
                    put_separators();
                    put_text($urandom_range(1) ? "-" : "+");
                    put_text("12");
                    put_eol();
                end
                default:
                begin
                    put_length_name();
                    put_filler(1, 4);
                    put_eol();
                end
            endcase
            put_eol();
        end
        else if (pick < 88)
        begin
            // unknown method, sometimes a near miss of a known one
            case ($urandom_range(3))
                0: put_text("GE");
                1: put_text("PO");
                2: put_text("POS");
                default: ;
            endcase
            put_filler(1, 8);
            put_eol();
            put_header_lines(2);
            put_eol();
        end
        else
        begin
            // raw noise, closed by a blank line so framing comes back
            repeat ($urandom_range(16, 1))
                req_q.push_back(8'($urandom_range(255)));
            put_eol();
            put_eol();
        end
    endfunction

    function automatic void add_case(input string text, input outcome_t code,
                                     input int unsigned total);
        case_text.push_back(text);
        case_code.push_back(code);
        case_total.push_back(total);
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        frame_status_t pinned;
        string         text;
        logic          pin;
        logic          paused;
        int unsigned   seg_start;
        logic [MAXLEN_W-1:0] limit_value;

        foreach (outcome_hits[i])
            outcome_hits[i] = 0;
        clear_request();
        body_limit = MAXLEN_RESET;
        paused = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_body_limit(MAXLEN_RESET);

        // directed requests at the reset limit of 65536
        //       request text                                              outcome       bytes
        add_case("GET\015\n\015\n",                                        OC_GET_DONE,   7);
        add_case("GET /\377\015\n\015\n",                                  OC_GET_DONE,   10);
        add_case("GETPOST\015\n\015\n",                                    OC_GET_DONE,   11);
        add_case("POST\015\nContent-Length: 3\015\n\015\nabc",             OC_POST_DONE,  30);
        add_case("POST\015\nCONTENT-LENGTH:0\015\n\015\n",                 OC_POST_DONE,  26);
        add_case("POST\015\ncontent-length: 4\015\n\015\n\015\n\015\n",    OC_POST_DONE,  31);
        add_case("POST /\015\nX: y\015\nContent-length 2\015\n\015\n~\001", OC_POST_DONE,  36);
        add_case("POST\015\nContent-length::  1\015\ncontent-length: 9\015\n\015\nx",
                                                                           OC_POST_DONE,  49);
        add_case("PUT\015\n\015\n",                                        OC_BAD_METHOD, 7);
        add_case("GEX /\015\n\015\n",                                      OC_BAD_METHOD, 9);
        add_case("P\015\n\015\n",                                          OC_BAD_METHOD, 5);
        add_case("\015\n\015\n",                                           OC_BAD_METHOD, 4);
        add_case("\001\015\n\015\n",                                       OC_BAD_METHOD, 5);
        add_case("POST\015\nHost: a\015\n\015\n",                          OC_NO_LENGTH,  17);
        add_case("POST\015\ncontent-length: -5\015\n\015\n",               OC_NO_LENGTH,  28);
        add_case("POST\015\ncontent-length:\015\n\015\n",                  OC_NO_LENGTH,  25);
        add_case("POST\015\ncontent-lengths: 2\015\n\015\n",               OC_NO_LENGTH,  28);
        add_case("POST\015\nContent-length: 99999999\015\n\015\n",         OC_TOO_LONG,   34);
        add_case("POST\015\nContent-length: 65537\015\n\015\n",            OC_TOO_LONG,   31);
        add_case("POST x\015\nhost: q\015\ncOnTeNt-LeNgTh : 5\015\n\015\n\000\377\200\177\015",
                                                                           OC_BUSY,       PREDICTED);

        for (int k = 0; k < case_text.size(); k++)
        begin
            text = case_text[k];
            for (int i = 0; i < text.len(); i++)
            begin
                pin = (case_total[k] != PREDICTED) && (i == text.len() - 1);
                pinned.done  = 1'b1;
                pinned.code  = case_code[k];
                pinned.total = case_total[k];
                send_byte(text[i], pin, pinned);
            end
        end
        wait_idle();

        // random traffic: each segment has its own limit and handshake mix
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 56;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 56;
                end
                default:
                begin
                    send_gap_pct = 6;
                    stall_pct    = 6;
                end
            endcase
            case (seg)
                0: limit_value = MAXLEN_RESET;
                1: limit_value = '0;
                2: limit_value = '1;
                3: limit_value = $urandom_range(40, 1);
                4: limit_value = '1;
                5: limit_value = $urandom_range(20'hfffff);
                6: limit_value = '0;
                default: limit_value = $urandom_range(12, 1);
            endcase
            set_body_limit(limit_value);

            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEG_BYTES)
            begin
                make_request();
                send_request();
                // one mid-stream hold until everything has come back
                if (seg == 1 && !paused && bytes_sent - seg_start > SEG_BYTES / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        $display("covered %0d bytes and %0d results: %0d get, %0d post, %0d bad method,",
                 bytes_sent, results_seen, outcome_hits[OC_GET_DONE],
                 outcome_hits[OC_POST_DONE], outcome_hits[OC_BAD_METHOD]);
        $display("%0d missing length, %0d too long, over %0d body limits and four handshake mixes",
                 outcome_hits[OC_NO_LENGTH], outcome_hits[OC_TOO_LONG], SEGMENTS + 1);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results still pending", status_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule
